>>> design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the serial command token parser
// character classes, token kinds, result codes and the result record
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam logic [7:0] CHAR_BSLASH = 8'h5c;
  localparam logic [7:0] CASE_MASK   = 8'hdf;
  localparam logic [7:0] CHAR_D      = 8'h44;
  localparam logic [7:0] CHAR_X      = 8'h58;

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_CNT_W = 3;
  localparam int unsigned RES_IDX_W = 2;

  typedef enum logic [1:0] {
    TK_PLAIN  = 2'd0,
    TK_BSLASH = 2'd1,
    TK_DEC    = 2'd2,
    TK_HEX    = 2'd3
  } tkind_e;

  typedef enum logic [0:0] {
    RK_NUMBER  = 1'b0,
    RK_SUMMARY = 1'b1
  } rkind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOBODY = 2'd1,
    ST_NOCMD  = 2'd2
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] number;
    logic [4:0]  slot;
    logic [7:0]  command_char;
    logic [5:0]  arg_count;
    logic [1:0]  status;
    logic        overflowed;
    logic        last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_used(input logic [7:0] b);
    logic [7:0] u;
    u = b & CASE_MASK;
    return (b == CHAR_BSLASH) || is_digit(b) || ((u >= 8'h41) && (u <= 8'h5a));
  endfunction

  // {ok, value}
  function automatic logic [4:0] dec_digit(input logic [7:0] b);
    logic [7:0] d;
    d = b - 8'h30;
    return is_digit(b) ? {1'b1, d[3:0]} : 5'd0;
  endfunction

  // {ok, value}, both letter cases
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] u;
    logic [7:0] d;
    u = b & CASE_MASK;
    d = u - 8'h37;
    if (is_digit(b)) begin
      return dec_digit(b);
    end else if ((u >= 8'h41) && (u <= 8'h46) && (b >= 8'h41)) begin
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

>>> design/scp_if.sv
// ----------------------------------------------------------------------------
// scp_if: stream channels of the serial command token parser
// received byte channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface scp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_message;

  modport source (output valid, output rx_byte, output end_of_message, input ready);
  modport sink   (input valid, input rx_byte, input end_of_message, output ready);
endinterface

interface scp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] number;
  logic [4:0]  slot;
  logic [7:0]  command_char;
  logic [5:0]  arg_count;
  logic [1:0]  status;
  logic        overflowed;
  logic        last;

  modport source (output valid, output kind, output number, output slot,
                  output command_char, output arg_count, output status,
                  output overflowed, output last, input ready);
  modport sink   (input valid, input kind, input number, input slot,
                  input command_char, input arg_count, input status,
                  input overflowed, input last, output ready);
endinterface

>>> design/scp_parse.sv
// ----------------------------------------------------------------------------
// scp_parse: message and token state with the per-byte update
// one byte per step, up to two results (number, summary) per step
// ----------------------------------------------------------------------------
module scp_parse #(
  parameter int unsigned BUF_LEN   = 32,
  parameter int unsigned TOKEN_MAX = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          eom_i,
  output logic [1:0]    push_cnt_o,
  output scp_pkg::res_t res_a_o,
  output scp_pkg::res_t res_b_o
);

  localparam int unsigned MB_W = $clog2(BUF_LEN + 1);
  localparam int unsigned VC_W = $clog2(BUF_LEN + 1);
  localparam int unsigned TL_W = $clog2(TOKEN_MAX + 1);

  logic               in_msg_q, in_msg_d;
  logic [7:0]         cmd_q, cmd_d;
  logic [TL_W-1:0]    tlen_q, tlen_d;
  scp_pkg::tkind_e    tkind_q, tkind_d;
  logic               tvalid_q, tvalid_d;
  logic [31:0]        acc_q, acc_d;
  logic               sat_q, sat_d;
  logic [VC_W-1:0]    vcnt_q, vcnt_d;
  logic [MB_W-1:0]    mbytes_q, mbytes_d;

  logic               used, body, start, fin, emit, use_hex;
  logic [7:0]         u;
  logic [4:0]         dsel;
  logic [35:0]        prod, sum;
  logic [31:0]        acc_new;
  logic               sat_new;
  logic [TL_W-1:0]    f_len;
  scp_pkg::tkind_e    f_kind;
  logic               f_valid;
  logic [31:0]        f_acc;
  logic               f_sat;
  logic [MB_W-1:0]    mb_a;
  logic [VC_W-1:0]    vcnt_a;
  logic               in_msg_a;
  logic [7:0]         cmd_a;
  scp_pkg::res_t      num_r, sum_r;

  // shared multiply-add unit, x10 or x16 with clamp
  always_comb begin
    use_hex = (tkind_q == scp_pkg::TK_HEX);
    dsel    = use_hex ? scp_pkg::hex_digit(byte_i) : scp_pkg::dec_digit(byte_i);
    prod    = use_hex ? {acc_q, 4'b0000}
                      : ({3'b000, acc_q, 1'b0} + {1'b0, acc_q, 3'b000});
    sum     = prod + {32'd0, dsel[3:0]};
    acc_new = (|sum[35:32]) ? 32'hffff_ffff : sum[31:0];
    sat_new = sat_q | (|sum[35:32]);
  end

  always_comb begin
    used     = scp_pkg::is_used(byte_i);
    u        = byte_i & scp_pkg::CASE_MASK;
    body     = in_msg_q && (mbytes_q < MB_W'(BUF_LEN));
    start    = !in_msg_q && used;
    f_len    = tlen_q;
    f_kind   = tkind_q;
    f_valid  = tvalid_q;
    f_acc    = acc_q;
    f_sat    = sat_q;
    fin      = 1'b0;
    mb_a     = mbytes_q;

    if (body) begin
      mb_a = mbytes_q + 1'b1;
      if (!used) begin
        fin = (tlen_q != '0);
      end else begin
        if (tlen_q == '0) begin
          f_kind  = (byte_i == scp_pkg::CHAR_BSLASH) ? scp_pkg::TK_BSLASH : scp_pkg::TK_PLAIN;
          f_valid = 1'b1;
          f_acc   = '0;
          f_sat   = 1'b0;
        end else begin
          case (tkind_q) inside
            scp_pkg::TK_BSLASH: begin
              if (u == scp_pkg::CHAR_D) begin
                f_kind = scp_pkg::TK_PLAIN;
              end else if (u == scp_pkg::CHAR_X) begin
                f_kind = scp_pkg::TK_HEX;
              end else begin
                f_kind = scp_pkg::TK_DEC;
                if (!dsel[4]) begin
                  f_valid = 1'b0;
                end else begin
                  f_acc = acc_new;
                  f_sat = sat_new;
                end
              end
            end
            scp_pkg::TK_DEC, scp_pkg::TK_HEX: begin
              if (!dsel[4]) begin
                f_valid = 1'b0;
              end else begin
                f_acc = acc_new;
                f_sat = sat_new;
              end
            end
            default: ;
          endcase
        end
        f_len = tlen_q + 1'b1;
        fin   = (f_len >= TL_W'(TOKEN_MAX)) || (mb_a >= MB_W'(BUF_LEN));
      end
    end
    // end flag closes an open token too
    if (eom_i && (f_len != '0)) begin
      fin = 1'b1;
    end

    emit = step_i && fin && (f_len != '0) && f_valid &&
           ((f_kind == scp_pkg::TK_DEC) || (f_kind == scp_pkg::TK_HEX)) &&
           (vcnt_q < VC_W'(BUF_LEN));
    vcnt_a   = vcnt_q + VC_W'(emit);
    in_msg_a = in_msg_q | start;
    cmd_a    = start ? byte_i : cmd_q;

    num_r.kind         = scp_pkg::RK_NUMBER;
    num_r.number       = f_acc;
    num_r.slot         = 5'(vcnt_q);
    num_r.command_char = cmd_a;
    num_r.arg_count    = 6'(vcnt_a);
    num_r.status       = scp_pkg::ST_OK;
    num_r.overflowed   = f_sat;
    num_r.last         = !eom_i;

    sum_r.kind         = scp_pkg::RK_SUMMARY;
    sum_r.number       = '0;
    sum_r.slot         = '0;
    sum_r.command_char = cmd_a;
    sum_r.arg_count    = 6'(vcnt_a);
    sum_r.status       = !in_msg_a ? scp_pkg::ST_NOCMD :
                         (mb_a == '0) ? scp_pkg::ST_NOBODY : scp_pkg::ST_OK;
    sum_r.overflowed   = 1'b0;
    sum_r.last         = 1'b1;
  end

  // results, number first
  always_comb begin
    push_cnt_o = 2'(emit) + 2'(step_i && eom_i);
    res_a_o    = emit ? num_r : sum_r;
    res_b_o    = sum_r;
  end

  // next state
  always_comb begin
    in_msg_d = in_msg_q;
    cmd_d    = cmd_q;
    tlen_d   = tlen_q;
    tkind_d  = tkind_q;
    tvalid_d = tvalid_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    vcnt_d   = vcnt_q;
    mbytes_d = mbytes_q;
    if (step_i) begin
      if (eom_i) begin
        in_msg_d = 1'b0;
        cmd_d    = '0;
        tlen_d   = '0;
        tkind_d  = scp_pkg::TK_PLAIN;
        tvalid_d = 1'b1;
        acc_d    = '0;
        sat_d    = 1'b0;
        vcnt_d   = '0;
        mbytes_d = '0;
      end else begin
        in_msg_d = in_msg_a;
        cmd_d    = cmd_a;
        vcnt_d   = vcnt_a;
        mbytes_d = mb_a;
        if (fin) begin
          tlen_d   = '0;
          tkind_d  = scp_pkg::TK_PLAIN;
          tvalid_d = 1'b1;
          acc_d    = '0;
          sat_d    = 1'b0;
        end else begin
          tlen_d   = f_len;
          tkind_d  = f_kind;
          tvalid_d = f_valid;
          acc_d    = f_acc;
          sat_d    = f_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
      cmd_q    <= '0;
      tlen_q   <= '0;
      tkind_q  <= scp_pkg::TK_PLAIN;
      tvalid_q <= 1'b1;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      vcnt_q   <= '0;
      mbytes_q <= '0;
    end else begin
      in_msg_q <= in_msg_d;
      cmd_q    <= cmd_d;
      tlen_q   <= tlen_d;
      tkind_q  <= tkind_d;
      tvalid_q <= tvalid_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      vcnt_q   <= vcnt_d;
      mbytes_q <= mbytes_d;
    end
  end

endmodule

>>> design/scp_res_fifo.sv
// ----------------------------------------------------------------------------
// scp_res_fifo: result queue
// shifting queue, two writes and one read per cycle, head at entry zero
// ----------------------------------------------------------------------------
module scp_res_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_cnt_i,
  input  scp_pkg::res_t wr_a_i,
  input  scp_pkg::res_t wr_b_i,
  input  logic          pop_i,
  output logic          room_o,
  output logic          head_valid_o,
  output scp_pkg::res_t head_o
);

  scp_pkg::res_t                   ent_q [scp_pkg::RES_DEPTH];
  scp_pkg::res_t                   ent_d [scp_pkg::RES_DEPTH];
  logic [scp_pkg::RES_CNT_W-1:0]   cnt_q, cnt_d;
  logic [scp_pkg::RES_IDX_W-1:0]   wr_idx;
  logic                            do_pop;

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = ent_q[0];
  // room for a full step of two results
  assign room_o       = (cnt_q <= scp_pkg::RES_CNT_W'(scp_pkg::RES_DEPTH - 2));
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (do_pop) begin
      for (int i = 0; i < scp_pkg::RES_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
    wr_idx = cnt_d[scp_pkg::RES_IDX_W-1:0];
    if (push_cnt_i != 2'd0) begin
      ent_d[wr_idx] = wr_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_d[wr_idx + 1'b1] = wr_b_i;
    end
    cnt_d = cnt_d + scp_pkg::RES_CNT_W'(push_cnt_i);
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/serial_command_token_parser_top.sv
// ----------------------------------------------------------------------------
// serial_command_token_parser_top: serial command token parser
// splits a received byte stream into a command byte and numeric arguments
// ----------------------------------------------------------------------------
// usage
//   rx_i carries one received byte per transfer with an end-of-message flag.
//   res_o carries results: a number result for every decimal or hex token
//   stored, and one summary result for every byte with the end flag set.
//   one byte gives zero, one or two results; last marks the final one.
// flow and throughput
//   a byte is held in the input register, then the parse logic updates the
//   message state and writes its results into a four-entry result queue;
//   the first result is taken from the queue head, which drives res_o.
//   one byte per cycle sustained while the queue has room (a step needs two
//   free queue entries); the token accumulator uses one multiply-add unit.
// reset
//   clears the message state (waiting for a command), the input valid flag
//   and the result queue count; no clearing pass is needed.
// stall
//   a stalled res_o holds its head result; the queue keeps taking bytes
//   until fewer than two entries are free, then the input register holds
//   its byte and rx_i.ready drops.
// ----------------------------------------------------------------------------
module serial_command_token_parser_top #(
  parameter int unsigned BUF_LEN   = 32,
  parameter int unsigned TOKEN_MAX = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scp_rx_if.sink    rx_i,
  scp_res_if.source res_o
);

  // input register
  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_byte_q;
  logic          in_eom_q;
  logic          rx_xfer;

  // parse step and queue
  logic          step;
  logic          room;
  logic [1:0]    push_cnt;
  scp_pkg::res_t res_a, res_b, head;
  logic          head_valid;

  // a step runs whenever a byte waits and the queue has room
  assign step        = in_valid_q && room;
  assign rx_i.ready  = !in_valid_q || step;
  assign rx_xfer     = rx_i.valid && rx_i.ready;
  assign in_valid_d  = rx_xfer ? 1'b1 : (step ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (rx_xfer) begin
      in_byte_q <= rx_i.rx_byte;
      in_eom_q  <= rx_i.end_of_message;
    end
  end

  scp_parse #(
    .BUF_LEN   (BUF_LEN),
    .TOKEN_MAX (TOKEN_MAX)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .eom_i      (in_eom_q),
    .push_cnt_o (push_cnt),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  scp_res_fifo u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .wr_a_i       (res_a),
    .wr_b_i       (res_b),
    .pop_i        (res_o.ready),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // result channel from the queue head
  assign res_o.valid        = head_valid;
  assign res_o.kind         = head.kind;
  assign res_o.number       = head.number;
  assign res_o.slot         = head.slot;
  assign res_o.command_char = head.command_char;
  assign res_o.arg_count    = head.arg_count;
  assign res_o.status       = head.status;
  assign res_o.overflowed   = head.overflowed;
  assign res_o.last         = head.last;

  // a summary always closes the results of its byte
  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == scp_pkg::RK_SUMMARY)) |-> res_o.last)
    else $error("summary result without last");

  // a number result has status ok and lies inside the argument count
  a_number_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == scp_pkg::RK_NUMBER)) |->
      ((res_o.status == scp_pkg::ST_OK) && ({1'b0, res_o.slot} < res_o.arg_count)))
    else $error("number result with bad slot or status");

  // a byte blocked by a full queue stays in the input register
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !room) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eom_q)))
    else $error("input byte lost while the queue was full");

  // a step with the end flag always pushes a result
  a_eom_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_eom_q) |-> (push_cnt != 2'd0))
    else $error("end of message without summary");

endmodule
